// ===== rtl/i2cmrt_pkg.sv =====
// Package for the I2C register transfer master: phase codes, actions, status codes.
// No dependencies.
`timescale 1ns / 1ps
package i2cmrt_pkg;
    localparam int MAX_BYTES_DEF = 16;
    localparam int PH_W = 5;
    localparam logic [4:0] PH_IDLE = 5'd0, PH_ST0 = 5'd1, PH_ST1 = 5'd2, PH_ST2 = 5'd3,
        PH_SB0 = 5'd4, PH_SB1 = 5'd5, PH_SB2 = 5'd6, PH_WA0 = 5'd7, PH_WA1 = 5'd8,
        PH_WA2 = 5'd9, PH_WA3 = 5'd10, PH_SP0 = 5'd11, PH_SP1 = 5'd12, PH_SP2 = 5'd13,
        PH_SP3 = 5'd14, PH_RB0 = 5'd15, PH_RB1 = 5'd16, PH_AK0 = 5'd17, PH_AK1 = 5'd18,
        PH_AK2 = 5'd19, PH_AK3 = 5'd20;
    localparam logic [2:0] GR_ADDR = 3'd0, GR_REG = 3'd1, GR_DATA = 3'd2,
        GR_RESTART = 3'd3, GR_RADDR = 3'd4, GR_RECV = 3'd5;
    localparam logic [1:0] ACT_TICK = 2'd0, ACT_LOAD = 2'd1, ACT_WRITE = 2'd2,
        ACT_READ = 2'd3;
    localparam logic [1:0] ST_OK = 2'd0, ST_BUSY = 2'd1, ST_BERR = 2'd2, ST_NACK = 2'd3;
    typedef struct packed {
        logic [1:0] action;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [4:0] length;
        logic [7:0] write_byte;
        logic       sda_in;
    } item_t;
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       done_res;
        logic [1:0] status;
    } res_t;
endpackage

// ===== rtl/i2cmrt_ram.sv =====
// Generic single-port-write RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module i2cmrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/i2cmrt_front.sv =====
// Front part: a two-entry queue toward the sequencer.
// Depends on i2cmrt_pkg.
`timescale 1ns / 1ps
module i2cmrt_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  i2cmrt_pkg::item_t   in_item,
    output logic                q_valid,
    input  logic                q_ready,
    output i2cmrt_pkg::item_t   q_item
);
    i2cmrt_pkg::item_t buf_reg [2];
    logic rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    logic push, pop;
    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = buf_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop = q_valid && q_ready;
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_reg] <= in_item;
        end
        if (!aresetn) begin
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wr_reg <= ~wr_reg;
            end
            if (pop) begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== rtl/i2cmrt_back.sv =====
// Back part: bus phase sequencer, write buffer and registered result stage.
// Depends on i2cmrt_pkg and i2cmrt_ram.
`timescale 1ns / 1ps
module i2cmrt_back #(
    parameter int MAX_BYTES = i2cmrt_pkg::MAX_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  i2cmrt_pkg::item_t q_item,
    output logic              out_valid,
    input  logic              out_ready,
    output i2cmrt_pkg::res_t  out_res
);
    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CW = $clog2(MAX_BYTES + 1);
    localparam int LW = (CW > 5) ? CW : 5;

    logic [4:0] ph_reg, ph_next;
    logic [2:0] gr_reg, gr_next;
    logic [3:0] bc_reg, bc_next;
    logic [7:0] sh_reg, sh_next;
    logic [CW-1:0] rem_reg, rem_next, fill_reg, fill_next, idx_reg, idx_next;
    logic rd_reg, rd_next, ack_reg, ack_next, scl_reg, scl_next, sda_reg, sda_next;
    logic [6:0] ta_reg, ta_next;
    logic [7:0] tr_reg, tr_next;
    logic [1:0] ss_reg, ss_next;
    logic ov_reg;
    i2cmrt_pkg::res_t or_reg, res_c;
    logic step, we, prefetch;
    logic [AW-1:0] raddr;
    logic [7:0] rdata;
    logic [LW-1:0] len_ext;
    logic [LW-1:0] max_ext;

    assign q_ready = !ov_reg || out_ready;
    assign step = q_valid && q_ready;
    assign out_valid = ov_reg;
    assign out_res = or_reg;
    assign len_ext = LW'(q_item.length);
    assign max_ext = LW'(MAX_BYTES);
    assign we = step && ph_reg == i2cmrt_pkg::PH_IDLE
        && q_item.action == i2cmrt_pkg::ACT_LOAD && fill_reg < CW'(MAX_BYTES);

    // RAM read address is the next byte at WA2/WA3 of a data byte, else the current index.
    assign prefetch = 1'b1;
    assign raddr = ((ph_reg == i2cmrt_pkg::PH_WA2 || ph_reg == i2cmrt_pkg::PH_WA3)
        && gr_reg == i2cmrt_pkg::GR_DATA) ? AW'(idx_reg + CW'(1)) : AW'(idx_reg);

    i2cmrt_ram #(.WIDTH(8), .DEPTH(MAX_BYTES)) u_buf (
        .aclk(aclk), .we(we), .waddr(AW'(fill_reg)), .wdata(q_item.write_byte),
        .raddr(raddr), .rdata(rdata)
    );

    always_comb begin
        ph_next = ph_reg; gr_next = gr_reg; bc_next = bc_reg; sh_next = sh_reg;
        rem_next = rem_reg; fill_next = fill_reg; idx_next = idx_reg; rd_next = rd_reg;
        ack_next = ack_reg; scl_next = scl_reg; sda_next = sda_reg; ta_next = ta_reg;
        tr_next = tr_reg; ss_next = ss_reg;
        res_c = '0;
        if (ph_reg == i2cmrt_pkg::PH_IDLE) begin
            if (q_item.action == i2cmrt_pkg::ACT_LOAD) begin
                if (we) begin
                    fill_next = fill_reg + CW'(1);
                end
            end else if (q_item.action != i2cmrt_pkg::ACT_TICK) begin
                rd_next = (q_item.action == i2cmrt_pkg::ACT_READ);
                ta_next = q_item.device_address;
                tr_next = q_item.register_address;
                rem_next = (len_ext > max_ext) ? CW'(MAX_BYTES) : CW'(len_ext);
                idx_next = '0; bc_next = '0; sh_next = '0;
                gr_next = i2cmrt_pkg::GR_ADDR; ss_next = i2cmrt_pkg::ST_OK;
                ack_next = 1'b0; ph_next = i2cmrt_pkg::PH_ST0;
            end
        end else if (q_item.action == i2cmrt_pkg::ACT_TICK) begin
            case (ph_reg)
                i2cmrt_pkg::PH_ST0: begin
                    scl_next = 1'b1; sda_next = 1'b1;
                    if (gr_reg == i2cmrt_pkg::GR_ADDR && !q_item.sda_in) begin
                        ph_next = i2cmrt_pkg::PH_IDLE; res_c.done_res = 1'b1;
                        res_c.status = i2cmrt_pkg::ST_BUSY;
                        if (!rd_reg) fill_next = '0;
                    end else ph_next = i2cmrt_pkg::PH_ST1;
                end
                i2cmrt_pkg::PH_ST1: begin
                    sda_next = 1'b0;
                    if (gr_reg == i2cmrt_pkg::GR_ADDR && q_item.sda_in) begin
                        ph_next = i2cmrt_pkg::PH_IDLE; res_c.done_res = 1'b1;
                        res_c.status = i2cmrt_pkg::ST_BERR;
                        if (!rd_reg) fill_next = '0;
                    end else ph_next = i2cmrt_pkg::PH_ST2;
                end
                i2cmrt_pkg::PH_ST2: begin
                    sda_next = 1'b0; bc_next = '0; ph_next = i2cmrt_pkg::PH_SB0;
                    if (gr_reg == i2cmrt_pkg::GR_RESTART) begin
                        gr_next = i2cmrt_pkg::GR_RADDR; sh_next = {ta_reg, 1'b1};
                    end else sh_next = {ta_reg, 1'b0};
                end
                i2cmrt_pkg::PH_SB0: begin
                    scl_next = 1'b0; ph_next = i2cmrt_pkg::PH_SB1;
                end
                i2cmrt_pkg::PH_SB1: begin
                    sda_next = sh_reg[7]; sh_next = {sh_reg[6:0], 1'b0};
                    ph_next = i2cmrt_pkg::PH_SB2;
                end
                i2cmrt_pkg::PH_SB2: begin
                    scl_next = 1'b1; bc_next = bc_reg + 4'd1;
                    ph_next = (bc_reg == 4'd7) ? i2cmrt_pkg::PH_WA0 : i2cmrt_pkg::PH_SB0;
                end
                i2cmrt_pkg::PH_WA0: begin
                    scl_next = 1'b0; ph_next = i2cmrt_pkg::PH_WA1;
                end
                i2cmrt_pkg::PH_WA1: begin
                    sda_next = 1'b1; ph_next = i2cmrt_pkg::PH_WA2;
                end
                i2cmrt_pkg::PH_WA2: begin
                    scl_next = 1'b1; ack_next = !q_item.sda_in;
                    ph_next = i2cmrt_pkg::PH_WA3;
                end
                i2cmrt_pkg::PH_WA3: begin
                    scl_next = 1'b0;
                    case (gr_reg)
                        i2cmrt_pkg::GR_ADDR: begin
                            if (!ack_reg) begin
                                ss_next = i2cmrt_pkg::ST_NACK; ph_next = i2cmrt_pkg::PH_SP0;
                            end else begin
                                gr_next = i2cmrt_pkg::GR_REG; sh_next = tr_reg;
                                bc_next = '0; ph_next = i2cmrt_pkg::PH_SB0;
                            end
                        end
                        i2cmrt_pkg::GR_REG: begin
                            if (rd_reg) begin
                                gr_next = i2cmrt_pkg::GR_RESTART;
                                ph_next = i2cmrt_pkg::PH_ST0;
                            end else if (!ack_reg) begin
                                ss_next = i2cmrt_pkg::ST_NACK; ph_next = i2cmrt_pkg::PH_SP0;
                            end else if (rem_reg == '0) begin
                                ss_next = i2cmrt_pkg::ST_OK; ph_next = i2cmrt_pkg::PH_SP0;
                            end else begin
                                gr_next = i2cmrt_pkg::GR_DATA; sh_next = rdata;
                                bc_next = '0; ph_next = i2cmrt_pkg::PH_SB0;
                            end
                        end
                        i2cmrt_pkg::GR_DATA: begin
                            if (!ack_reg) begin
                                ss_next = i2cmrt_pkg::ST_NACK; ph_next = i2cmrt_pkg::PH_SP0;
                            end else begin
                                idx_next = idx_reg + CW'(1);
                                rem_next = rem_reg - CW'(1);
                                if (rem_reg == CW'(1)) begin
                                    ss_next = i2cmrt_pkg::ST_OK;
                                    ph_next = i2cmrt_pkg::PH_SP0;
                                end else begin
                                    sh_next = rdata; bc_next = '0;
                                    ph_next = i2cmrt_pkg::PH_SB0;
                                end
                            end
                        end
                        default: begin
                            if (rem_reg == '0) begin
                                ss_next = i2cmrt_pkg::ST_OK; ph_next = i2cmrt_pkg::PH_SP0;
                            end else begin
                                gr_next = i2cmrt_pkg::GR_RECV; bc_next = '0;
                                sh_next = '0; ph_next = i2cmrt_pkg::PH_RB0;
                            end
                        end
                    endcase
                end
                i2cmrt_pkg::PH_SP0: begin
                    scl_next = 1'b0; ph_next = i2cmrt_pkg::PH_SP1;
                end
                i2cmrt_pkg::PH_SP1: begin
                    sda_next = 1'b0; ph_next = i2cmrt_pkg::PH_SP2;
                end
                i2cmrt_pkg::PH_SP2: begin
                    scl_next = 1'b1; ph_next = i2cmrt_pkg::PH_SP3;
                end
                i2cmrt_pkg::PH_SP3: begin
                    sda_next = 1'b1; ph_next = i2cmrt_pkg::PH_IDLE;
                    res_c.done_res = 1'b1; res_c.status = ss_reg;
                    if (!rd_reg) fill_next = '0;
                end
                i2cmrt_pkg::PH_RB0: begin
                    scl_next = 1'b0; sda_next = 1'b1; ph_next = i2cmrt_pkg::PH_RB1;
                end
                i2cmrt_pkg::PH_RB1: begin
                    scl_next = 1'b1; sh_next = {sh_reg[6:0], q_item.sda_in};
                    bc_next = bc_reg + 4'd1;
                    if (bc_reg == 4'd7) begin
                        res_c.read_valid = 1'b1; res_c.read_byte = {sh_reg[6:0], q_item.sda_in};
                        ph_next = i2cmrt_pkg::PH_AK0;
                    end else ph_next = i2cmrt_pkg::PH_RB0;
                end
                i2cmrt_pkg::PH_AK0: begin
                    scl_next = 1'b0; ph_next = i2cmrt_pkg::PH_AK1;
                end
                i2cmrt_pkg::PH_AK1: begin
                    sda_next = (rem_reg == CW'(1)); ph_next = i2cmrt_pkg::PH_AK2;
                end
                i2cmrt_pkg::PH_AK2: begin
                    scl_next = 1'b1; ph_next = i2cmrt_pkg::PH_AK3;
                end
                i2cmrt_pkg::PH_AK3: begin
                    scl_next = 1'b0;
                    if (rem_reg <= CW'(1)) begin
                        rem_next = '0; ss_next = i2cmrt_pkg::ST_OK;
                        ph_next = i2cmrt_pkg::PH_SP0;
                    end else begin
                        rem_next = rem_reg - CW'(1); bc_next = '0; sh_next = '0;
                        ph_next = i2cmrt_pkg::PH_RB0;
                    end
                end
                default: ph_next = i2cmrt_pkg::PH_IDLE;
            endcase
        end
        res_c.scl_out = scl_next;
        res_c.sda_out = sda_next;
        res_c.busy_res = (ph_next != i2cmrt_pkg::PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            or_reg <= res_c;
        end
        if (!aresetn) begin
            ph_reg <= i2cmrt_pkg::PH_IDLE; gr_reg <= i2cmrt_pkg::GR_ADDR;
            bc_reg <= '0; sh_reg <= '0; rem_reg <= '0; fill_reg <= '0; idx_reg <= '0;
            rd_reg <= 1'b0; ack_reg <= 1'b0; scl_reg <= 1'b1; sda_reg <= 1'b1;
            ta_reg <= '0; tr_reg <= '0; ss_reg <= i2cmrt_pkg::ST_OK; ov_reg <= 1'b0;
        end else begin
            if (step) begin
                ph_reg <= ph_next; gr_reg <= gr_next; bc_reg <= bc_next; sh_reg <= sh_next;
                rem_reg <= rem_next; fill_reg <= fill_next; idx_reg <= idx_next;
                rd_reg <= rd_next; ack_reg <= ack_next; scl_reg <= scl_next;
                sda_reg <= sda_next; ta_reg <= ta_next; tr_reg <= tr_next; ss_reg <= ss_next;
                ov_reg <= 1'b1;
            end else if (out_ready && prefetch) begin
                ov_reg <= 1'b0;
            end
        end
    end
endmodule

// ===== rtl/i2c_master_register_transfer_top.sv =====
// Top level of the I2C register transfer master.
// Depends on i2cmrt_pkg, i2cmrt_front and i2cmrt_back.
`timescale 1ns / 1ps
// Every transfer in gives exactly one transfer out: the line levels after that step, busy,
// any received byte and the done and status flags. A tick advances the bus by one phase.
// One item is taken per clock while the result side accepts; an item passes from input to
// result through the input queue and the output register of the phase sequencer, and
// waits in them while the result side holds off.
module i2c_master_register_transfer_top #(
    parameter int MAX_BYTES = i2cmrt_pkg::MAX_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[1:0], device_address[8:2], register_address[16:9], length[21:17],
    // write_byte[29:22], sda_in[30]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // scl_out[0], sda_out[1], busy_res[2], read_byte[10:3], read_valid[11],
    // done_res[12], status[14:13]
    output logic [15:0] m_tdata
);
    i2cmrt_pkg::item_t in_item, q_item;
    i2cmrt_pkg::res_t res;
    logic q_valid, q_ready;

    assign in_item.action = s_tdata[1:0];
    assign in_item.device_address = s_tdata[8:2];
    assign in_item.register_address = s_tdata[16:9];
    assign in_item.length = s_tdata[21:17];
    assign in_item.write_byte = s_tdata[29:22];
    assign in_item.sda_in = s_tdata[30];
    assign m_tdata = {1'b0, res.status, res.done_res, res.read_valid, res.read_byte,
        res.busy_res, res.sda_out, res.scl_out};

    i2cmrt_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    i2cmrt_back #(.MAX_BYTES(MAX_BYTES)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );
endmodule

// ===== test/i2c_master_register_transfer_top_tb.sv =====
// Testbench for the I2C register transfer master: drives command and tick transfers,
// predicts every result from its own bus-phase model and compares field by field.
// Depends on i2cmrt_pkg and the i2c_master_register_transfer_top RTL.
`timescale 1ns / 1ps
module i2c_master_register_transfer_top_tb;
    import i2cmrt_pkg::*;

    localparam int DEPTH = MAX_BYTES_DEF;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef enum logic [2:0] {
        SEG_ADDR, SEG_REG, SEG_DATA, SEG_RESTART, SEG_RADDR, SEG_RECV
    } segment_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    i2c_master_register_transfer_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Bus model state.
    logic [4:0] phase;
    logic [3:0] bit_cnt;
    logic [7:0] shreg;
    logic [4:0] remaining;
    logic [4:0] fill;
    logic [7:0] wbuf [DEPTH];
    logic       is_read;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic       scl_lvl, sda_lvl;
    segment_t   segment;
    logic [4:0] byte_idx;
    logic       acked;
    logic [1:0] stop_code;
    res_t       step_res;

    res_t  expected_results [$];
    int    errors = 0;
    longint cycles = 0;
    bit    hold_off = 1'b0;
    int    hold_cycles = 0;
    int    hold_requests = 0;
    int    hold_grants = 0;
    int    items_sent = 0;

    function automatic void end_transaction(logic [1:0] code);
        phase = PH_IDLE;
        step_res.done_res = 1'b1;
        step_res.status = code;
        if (!is_read) fill = '0;
    endfunction

    function automatic void start_stop(logic [1:0] code);
        stop_code = code;
        phase = PH_SP0;
    endfunction

    function automatic void shift_out(logic [7:0] value);
        shreg = value;
        bit_cnt = '0;
        phase = PH_SB0;
    endfunction

    function automatic void next_after_ack();
        case (segment)
            SEG_ADDR: begin
                if (!acked) start_stop(ST_NACK);
                else begin
                    segment = SEG_REG;
                    shift_out(reg_addr);
                end
            end
            SEG_REG: begin
                if (is_read) begin
                    segment = SEG_RESTART;
                    phase = PH_ST0;
                end else if (!acked) start_stop(ST_NACK);
                else if (remaining == 0) start_stop(ST_OK);
                else begin
                    segment = SEG_DATA;
                    shift_out(wbuf[byte_idx]);
                end
            end
            SEG_DATA: begin
                if (!acked) start_stop(ST_NACK);
                else begin
                    byte_idx++;
                    remaining--;
                    if (remaining == 0) start_stop(ST_OK);
                    else shift_out(wbuf[byte_idx]);
                end
            end
            default: begin
                if (remaining == 0) start_stop(ST_OK);
                else begin
                    segment = SEG_RECV;
                    bit_cnt = '0;
                    shreg = '0;
                    phase = PH_RB0;
                end
            end
        endcase
    endfunction

    function automatic void bus_tick(logic sdi);
        case (phase)
            PH_ST0: begin
                scl_lvl = 1'b1; sda_lvl = 1'b1;
                if (segment == SEG_ADDR && !sdi) end_transaction(ST_BUSY);
                else phase = PH_ST1;
            end
            PH_ST1: begin
                sda_lvl = 1'b0;
                if (segment == SEG_ADDR && sdi) end_transaction(ST_BERR);
                else phase = PH_ST2;
            end
            PH_ST2: begin
                sda_lvl = 1'b0;
                if (segment == SEG_RESTART) begin
                    segment = SEG_RADDR;
                    shift_out({dev_addr, 1'b1});
                end else shift_out({dev_addr, 1'b0});
            end
            PH_SB0: begin scl_lvl = 1'b0; phase = PH_SB1; end
            PH_SB1: begin
                sda_lvl = shreg[7];
                shreg = shreg << 1;
                phase = PH_SB2;
            end
            PH_SB2: begin
                scl_lvl = 1'b1;
                bit_cnt++;
                phase = (bit_cnt >= 8) ? PH_WA0 : PH_SB0;
            end
            PH_WA0: begin scl_lvl = 1'b0; phase = PH_WA1; end
            PH_WA1: begin sda_lvl = 1'b1; phase = PH_WA2; end
            PH_WA2: begin scl_lvl = 1'b1; acked = !sdi; phase = PH_WA3; end
            PH_WA3: begin scl_lvl = 1'b0; next_after_ack(); end
            PH_SP0: begin scl_lvl = 1'b0; phase = PH_SP1; end
            PH_SP1: begin sda_lvl = 1'b0; phase = PH_SP2; end
            PH_SP2: begin scl_lvl = 1'b1; phase = PH_SP3; end
            PH_SP3: begin sda_lvl = 1'b1; end_transaction(stop_code); end
            PH_RB0: begin scl_lvl = 1'b0; sda_lvl = 1'b1; phase = PH_RB1; end
            PH_RB1: begin
                scl_lvl = 1'b1;
                shreg = {shreg[6:0], sdi};
                bit_cnt++;
                if (bit_cnt >= 8) begin
                    step_res.read_valid = 1'b1;
                    step_res.read_byte = shreg;
                    phase = PH_AK0;
                end else phase = PH_RB0;
            end
            PH_AK0: begin scl_lvl = 1'b0; phase = PH_AK1; end
            PH_AK1: begin sda_lvl = (remaining == 1); phase = PH_AK2; end
            PH_AK2: begin scl_lvl = 1'b1; phase = PH_AK3; end
            PH_AK3: begin
                scl_lvl = 1'b0;
                if (remaining > 0) remaining--;
                if (remaining == 0) start_stop(ST_OK);
                else begin
                    bit_cnt = '0;
                    shreg = '0;
                    phase = PH_RB0;
                end
            end
            default: phase = PH_IDLE;
        endcase
    endfunction

    function automatic res_t predict_bus_step(item_t it);
        step_res = '0;
        if (phase == PH_IDLE) begin
            if (it.action == ACT_LOAD) begin
                if (fill < DEPTH) begin
                    wbuf[fill] = it.write_byte;
                    fill++;
                end
            end else if (it.action == ACT_WRITE || it.action == ACT_READ) begin
                is_read = (it.action == ACT_READ);
                dev_addr = it.device_address;
                reg_addr = it.register_address;
                remaining = (it.length > DEPTH) ? 5'(DEPTH) : it.length;
                byte_idx = '0;
                bit_cnt = '0;
                shreg = '0;
                segment = SEG_ADDR;
                stop_code = ST_OK;
                acked = 1'b0;
                phase = PH_ST0;
            end
        end else if (it.action == ACT_TICK) begin
            bus_tick(it.sda_in);
        end
        step_res.scl_out = scl_lvl;
        step_res.sda_out = sda_lvl;
        step_res.busy_res = (phase != PH_IDLE);
        return step_res;
    endfunction

    function automatic logic [31:0] pack_item(item_t it);
        return {1'b0, it.sda_in, it.write_byte, it.length, it.register_address,
                it.device_address, it.action};
    endfunction

    task automatic send_item(item_t it);
        int gap;
        if ($urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_item(it);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(predict_bus_step(it));
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic item_t random_item(logic [1:0] act);
        item_t it;
        it.action = act;
        it.device_address = $urandom;
        it.register_address = $urandom;
        it.length = $urandom_range(0, 31);
        it.write_byte = $urandom;
        it.sda_in = $urandom;
        return it;
    endfunction

    task automatic send_tick(logic sdi);
        item_t it;
        it = random_item(ACT_TICK);
        it.sda_in = sdi;
        send_item(it);
    endtask

    task automatic load_byte(logic [7:0] b);
        item_t it;
        it = random_item(ACT_LOAD);
        it.write_byte = b;
        send_item(it);
    endtask

    task automatic begin_transfer(logic [1:0] act, logic [6:0] dev, logic [7:0] rg,
                                  logic [4:0] len);
        item_t it;
        it = random_item(act);
        it.device_address = dev;
        it.register_address = rg;
        it.length = len;
        send_item(it);
    endtask

    // Ticks with a plausible bus: free at start, acks given unless nack_rate hits.
    task automatic run_bus(int nack_rate);
        logic sdi;
        while (phase != PH_IDLE) begin
            case (phase)
                PH_ST0: sdi = 1'b1;
                PH_ST1: sdi = 1'b0;
                PH_WA2: sdi = ($urandom_range(0, 99) < nack_rate);
                default: sdi = $urandom;
            endcase
            if ($urandom_range(0, 29) == 0) sdi = ~sdi;
            send_tick(sdi);
        end
    endtask

    task automatic test_directed();
        item_t it;
        load_byte(8'h00);
        load_byte(8'hFF);
        begin_transfer(ACT_READ, 7'h00, 8'h00, 5'd31);
        it = random_item(ACT_LOAD);
        send_item(it);
        run_bus(0);
        begin_transfer(ACT_READ, 7'h2A, 8'h5A, 5'd1);
        send_tick(1'b0);
        begin_transfer(ACT_READ, 7'h2A, 8'h5A, 5'd1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        run_bus(100);
        send_tick(1'b0);
        drain_results();
    endtask

    task automatic test_full_buffer();
        for (int i = 0; i < DEPTH + 2; i++) load_byte($urandom);
        begin_transfer(ACT_WRITE, $urandom, $urandom, 5'd2);
        run_bus(0);
        drain_results();
    endtask

    task automatic test_write_nack();
        for (int i = 0; i < 2; i++) load_byte($urandom);
        begin_transfer(ACT_WRITE, $urandom, $urandom, 5'd2);
        run_bus(40);
        drain_results();
    endtask

    task automatic test_receiver_hold();
        hold_requests++;
        begin_transfer(ACT_WRITE, $urandom, $urandom, 5'd0);
        run_bus(10);
        for (int i = 0; i < 40; i++) send_tick($urandom);
        drain_results();
    endtask

    task automatic test_random(int target);
        int rounds;
        int n;
        logic [1:0] act;
        item_t it;
        rounds = 0;
        while (items_sent < target || rounds < 2) begin
            if ($urandom_range(0, 9) < 8) begin
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++) load_byte($urandom);
                act = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
                n = (act == ACT_WRITE) ? fill + n : $urandom_range(0, 31);
                if ($urandom_range(0, 9) == 0 && act == ACT_READ) n = $urandom_range(17, 31);
                if (act == ACT_WRITE) n = (fill < 4) ? fill : $urandom_range(0, fill);
                begin_transfer(act, $urandom, $urandom,
                               (act == ACT_READ && n > 6 && $urandom_range(0, 3) != 0)
                               ? 5'($urandom_range(0, 4)) : 5'(n));
                run_bus($urandom_range(0, 1) ? 0 : 15);
            end else begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    if (phase == PH_IDLE && $urandom_range(0, 2) == 0 && fill == 0) begin
                        it = random_item(2'($urandom_range(2, 3)));
                        if (it.action == ACT_WRITE) it.length = '0;
                        send_item(it);
                    end else if (phase != PH_IDLE || $urandom_range(0, 1))
                        send_tick($urandom);
                    else load_byte($urandom);
                end
                run_bus(50);
            end
            rounds++;
        end
        drain_results();
    endtask

    // Result checker with its own randomized backpressure.
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got = res_t'(m_tdata[14:0]);
            got = '{scl_out: m_tdata[0], sda_out: m_tdata[1], busy_res: m_tdata[2],
                    read_byte: m_tdata[10:3], read_valid: m_tdata[11],
                    done_res: m_tdata[12], status: m_tdata[14:13]};
            if (expected_results.size() == 0) begin
                $error("unexpected transfer out: %h", m_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.scl_out !== want.scl_out) begin
                    $error("scl_out: expected %0d, got %0d", want.scl_out, got.scl_out);
                    errors++;
                end
                if (got.sda_out !== want.sda_out) begin
                    $error("sda_out: expected %0d, got %0d", want.sda_out, got.sda_out);
                    errors++;
                end
                if (got.busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
                    errors++;
                end
                if (got.read_byte !== want.read_byte) begin
                    $error("read_byte: expected %h, got %h", want.read_byte, got.read_byte);
                    errors++;
                end
                if (got.read_valid !== want.read_valid) begin
                    $error("read_valid: expected %0d, got %0d", want.read_valid,
                           got.read_valid);
                    errors++;
                end
                if (got.done_res !== want.done_res) begin
                    $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_requests != hold_grants) begin
            m_tready <= 1'b0;
            hold_cycles <= 200;
            hold_off <= 1'b1;
            hold_grants <= hold_grants + 1;
        end else if (hold_off) begin
            m_tready <= 1'b0;
            if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
            else hold_off <= 1'b0;
        end else if ($urandom_range(0, 199) < 3) begin
            m_tready <= 1'b0;
            hold_cycles <= $urandom_range(8, 40);
            hold_off <= 1'b1;
        end else if ($urandom_range(0, 99) < 60) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("i2c_master_register_transfer_top test failed");
            $finish;
        end
    end

    initial begin
        phase = PH_IDLE;
        bit_cnt = '0;
        shreg = '0;
        remaining = '0;
        fill = '0;
        is_read = 1'b0;
        dev_addr = '0;
        reg_addr = '0;
        scl_lvl = 1'b1;
        sda_lvl = 1'b1;
        segment = SEG_ADDR;
        byte_idx = '0;
        acked = 1'b0;
        stop_code = ST_OK;
        for (int i = 0; i < DEPTH; i++) wbuf[i] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_buffer();
        test_write_nack();
        test_receiver_hold();
        test_random(650);
        drain_results();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("i2c_master_register_transfer_top test passed");
        end else begin
            $display("i2c_master_register_transfer_top test failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/i2cmrt_pkg.sv
rtl/i2cmrt_ram.sv
rtl/i2cmrt_front.sv
rtl/i2cmrt_back.sv
rtl/i2c_master_register_transfer_top.sv
test/i2c_master_register_transfer_top_tb.sv
